>>> src/hash_table_probe_insert_assert.svh
// Assertion macros shared by the hash table checker.
`ifndef HASH_TABLE_PROBE_INSERT_ASSERT_SVH
`define HASH_TABLE_PROBE_INSERT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define HTPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define HTPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle after reset is seen low.
`define HTPI_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

>>> src/htpi_pkg.sv
// Types and constants for the open-addressing hash table.
`default_nettype none

package htpi_pkg;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int KEY_W    = 34;
    localparam int NAME_W   = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // Request codes (code 3 decodes as a read)
    localparam logic [REQ_W-1:0] REQ_LINEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUAD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;

    // Key reduction: nibbles folded into the remainder, five per cycle
    localparam int DIGIT_W       = 4;
    localparam int DIGITS_PER_CY = 5;
    localparam int HASH_CY       = 2;
    localparam int HASH_W        = DIGIT_W * DIGITS_PER_CY * HASH_CY;
    localparam int HASH_STEP_W   = DIGIT_W * DIGITS_PER_CY;

    // Width that holds any read slot and the largest table size
    localparam int RS_EXT_W = 11;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified request, as it travels from front to back
    typedef struct packed {
        logic                is_read;
        logic                quad;
        logic                in_range;
        logic [SLOT_W-1:0]   read_slot;
        logic [KEY_W-1:0]    key;
        logic [NAME_W-1:0]   name;
    } t_job;

endpackage

`default_nettype wire

>>> src/hash_table_probe_insert.sv
// Top level of the open-addressing hash table with linear and quadratic probing.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_ready  i_req_type, i_record_key, i_record_name, i_read_slot
//   result    out        o_valid / i_ready  o_status, o_slot, o_slot_valid, o_key_out, o_name_out
//
// Front end takes one request at a time (accept, key mod TABLE_SIZE at five nibbles
// a cycle, hand-off to the queue); a read skips the key reduction.
// Back end dispatches a job, then probes the occupancy map
// (up to TABLE_SIZE probes); a read goes through the registered memory port.
// Reset clears the occupancy map at once; the block is ready in the cycle after reset.
// A stalled result holds the back end; the two-entry queue keeps the front running until it fills.
`default_nettype none

module hash_table_probe_insert #(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [htpi_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [htpi_pkg::KEY_W-1:0]     i_record_key,
    input  wire logic [htpi_pkg::NAME_W-1:0]    i_record_name,
    input  wire logic [htpi_pkg::SLOT_W-1:0]    i_read_slot,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [htpi_pkg::STATUS_W-1:0]       o_status,
    output logic [htpi_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_slot_valid,
    output logic [htpi_pkg::KEY_W-1:0]          o_key_out,
    output logic [htpi_pkg::NAME_W-1:0]         o_name_out
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic           w_push;
    logic           w_full;
    htpi_pkg::t_job w_fr_job;
    logic [IW-1:0]  w_fr_home;
    logic           w_q_valid;
    logic           w_pop;
    htpi_pkg::t_job w_q_job;
    logic [IW-1:0]  w_q_home;

    htpi_front #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_record_key  (i_record_key),
        .i_record_name (i_record_name),
        .i_read_slot   (i_read_slot),
        .o_push        (w_push),
        .i_full        (w_full),
        .o_job         (w_fr_job),
        .o_home        (w_fr_home)
    );

    htpi_queue #(
        .IW (IW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_job   (w_fr_job),
        .i_home  (w_fr_home),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_home  (w_q_home)
    );

    htpi_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .IW         (IW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_q_valid),
        .o_job_pop    (w_pop),
        .i_job        (w_q_job),
        .i_home       (w_q_home),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_slot_valid (o_slot_valid),
        .o_key_out    (o_key_out),
        .o_name_out   (o_name_out)
    );

endmodule

`default_nettype wire

>>> src/htpi_front.sv
// Front end: accepts requests, decodes them and reduces the key to its home slot.
`default_nettype none

module htpi_front #(
    parameter int TABLE_SIZE = 16,
    parameter int IW         = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [htpi_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [htpi_pkg::KEY_W-1:0]     i_record_key,
    input  wire logic [htpi_pkg::NAME_W-1:0]    i_record_name,
    input  wire logic [htpi_pkg::SLOT_W-1:0]    i_read_slot,
    output logic                                o_push,
    input  wire logic                           i_full,
    output htpi_pkg::t_job                      o_job,
    output logic [IW-1:0]                       o_home
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int VW   = IW + htpi_pkg::DIGIT_W;
    localparam int HW   = htpi_pkg::HASH_W;
    localparam int SW   = htpi_pkg::HASH_STEP_W;
    localparam int DW   = htpi_pkg::DIGIT_W;
    localparam int RW   = htpi_pkg::RS_EXT_W;
    localparam int CYW  = $clog2(htpi_pkg::HASH_CY);

    logic [1:0]          r_state;
    logic [CYW-1:0]      r_cyc;
    logic [HW-1:0]       r_sh;
    logic [IW-1:0]       r_rem;
    htpi_pkg::t_job      r_job;
    logic [IW-1:0]       r_home;
    logic [IW-1:0]       n_rem;
    logic [RW-1:0]       w_rs_ext;
    logic                w_accept;

    // One nibble into the remainder: (rem*16 + dig) mod TABLE_SIZE.
    // The value stays below 16*TABLE_SIZE, so one of fifteen constant multiples suffices.
    function automatic logic [IW-1:0] f_mod_digit(input logic [IW-1:0] rem,
                                                  input logic [DW-1:0] dig);
        logic [VW-1:0] v;
        logic [VW-1:0] res;
        v   = {rem, dig};
        res = v;
        for (int m = 1; m < (1 << DW); m++) begin
            if (v >= VW'(m * TABLE_SIZE)) begin
                res = v - VW'(m * TABLE_SIZE);
            end
        end
        return res[IW-1:0];
    endfunction

    assign o_ready  = (r_state == F_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_rs_ext = RW'(i_read_slot);

    // Five nibbles of the key per cycle, most significant first
    always_comb begin
        n_rem = r_rem;
        for (int d = 0; d < htpi_pkg::DIGITS_PER_CY; d++) begin
            n_rem = f_mod_digit(n_rem, r_sh[HW-1-d*DW -: DW]);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cyc   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    r_cyc <= '0;
                    if (w_accept) begin
                        r_state <= (i_req_type >= htpi_pkg::REQ_READ) ? F_PUSH : F_HASH;
                    end
                end
                F_HASH: begin
                    r_cyc <= r_cyc + 1'b1;
                    if (r_cyc == CYW'(htpi_pkg::HASH_CY - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Payload capture and key reduction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.is_read   <= (i_req_type >= htpi_pkg::REQ_READ);
            r_job.quad      <= (i_req_type == htpi_pkg::REQ_QUAD);
            r_job.in_range  <= (w_rs_ext < RW'(TABLE_SIZE));
            r_job.read_slot <= i_read_slot;
            r_job.key       <= i_record_key;
            r_job.name      <= i_record_name;
            r_home          <= w_rs_ext[IW-1:0];
            r_sh            <= HW'(i_record_key);
            r_rem           <= '0;
        end else if (r_state == F_HASH) begin
            r_sh  <= r_sh << SW;
            r_rem <= n_rem;
            if (r_cyc == CYW'(htpi_pkg::HASH_CY - 1)) begin
                r_home <= n_rem;
            end
        end
    end

    assign o_push = (r_state == F_PUSH);
    assign o_job  = r_job;
    assign o_home = r_home;

endmodule

`default_nettype wire

>>> src/htpi_queue.sv
// Two-entry queue of classified requests between front and back.
`default_nettype none

module htpi_queue #(
    parameter int IW = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire htpi_pkg::t_job i_job,
    input  wire logic [IW-1:0]  i_home,
    output logic                o_valid,
    input  wire logic           i_pop,
    output htpi_pkg::t_job      o_job,
    output logic [IW-1:0]       o_home
);

    localparam int PW = htpi_pkg::QPTR_W;
    localparam int CW = htpi_pkg::QCNT_W;

    htpi_pkg::t_job r_job  [htpi_pkg::QUEUE_DEPTH];
    logic [IW-1:0]  r_home [htpi_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_cnt == CW'(htpi_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_job   = r_job[r_rp];
    assign o_home  = r_home[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_job[r_wp]  <= i_job;
            r_home[r_wp] <= i_home;
        end
    end

endmodule

`default_nettype wire

>>> src/htpi_back.sv
// Back end: probes the occupancy map, writes records, serves reads, holds the result.
`default_nettype none

module htpi_back #(
    parameter int TABLE_SIZE = 16,
    parameter int IW         = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_job_valid,
    output logic                                o_job_pop,
    input  wire htpi_pkg::t_job                 i_job,
    input  wire logic [IW-1:0]                  i_home,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [htpi_pkg::STATUS_W-1:0]       o_status,
    output logic [htpi_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_slot_valid,
    output logic [htpi_pkg::KEY_W-1:0]          o_key_out,
    output logic [htpi_pkg::NAME_W-1:0]         o_name_out
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_PROBE = 2'd1;
    localparam logic [1:0] B_READ  = 2'd2;

    localparam int CW = IW + 1;
    localparam int SW = htpi_pkg::SLOT_W;
    localparam logic [CW-1:0] TS_C   = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] LAST_C = CW'(TABLE_SIZE - 1);

    // Record storage
    logic [htpi_pkg::KEY_W-1:0]  key_mem  [TABLE_SIZE];
    logic [htpi_pkg::NAME_W-1:0] name_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]       r_occ;

    logic [1:0]                  r_state;
    htpi_pkg::t_job              r_job;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_inc;
    logic [CW-1:0]               r_cnt;
    logic                        r_rd_occ;
    logic [htpi_pkg::KEY_W-1:0]  r_rd_key;
    logic [htpi_pkg::NAME_W-1:0] r_rd_name;

    logic                        r_o_valid;
    logic [htpi_pkg::STATUS_W-1:0] r_status;
    logic [SW-1:0]               r_slot;
    logic                        r_slot_valid;
    logic [htpi_pkg::KEY_W-1:0]  r_key;
    logic [htpi_pkg::NAME_W-1:0] r_name;

    logic                        w_room;
    logic                        w_free;
    logic                        w_last;
    logic                        w_wr;
    logic                        w_rd;
    logic                        w_done_probe;
    logic                        w_done_read;
    logic [CW-1:0]               w_idx_sum;
    logic [CW-1:0]               w_inc_sum;
    logic [IW-1:0]               n_idx;
    logic [IW-1:0]               n_inc;

    assign w_room       = !r_o_valid || i_ready;
    assign w_free       = !r_occ[r_idx];
    assign w_last       = (r_cnt == LAST_C);
    assign o_job_pop    = (r_state == B_IDLE) && i_job_valid;
    assign w_rd         = o_job_pop && i_job.is_read;
    assign w_wr         = (r_state == B_PROBE) && w_free && w_room;
    assign w_done_probe = (r_state == B_PROBE) && (w_free || w_last) && w_room;
    assign w_done_read  = (r_state == B_READ) && w_room;

    // Next probe: index advances by the step, step grows by two for quadratic
    always_comb begin
        w_idx_sum = {1'b0, r_idx} + {1'b0, r_inc};
        w_inc_sum = {1'b0, r_inc} + CW'(2);
        n_idx = (w_idx_sum >= TS_C) ? IW'(w_idx_sum - TS_C) : IW'(w_idx_sum);
        if (r_job.quad) begin
            n_inc = (w_inc_sum >= TS_C) ? IW'(w_inc_sum - TS_C) : IW'(w_inc_sum);
        end else begin
            n_inc = r_inc;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_occ   <= '0;
        end else begin
            if (w_wr) begin
                r_occ[r_idx] <= 1'b1;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= i_job.is_read ? B_READ : B_PROBE;
                    end
                end
                B_PROBE: begin
                    if (w_done_probe) begin
                        r_state <= B_IDLE;
                    end
                end
                B_READ: begin
                    if (w_done_read) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    // Probe datapath
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job    <= i_job;
            r_idx    <= i_home;
            r_inc    <= IW'(1);
            r_cnt    <= '0;
            r_rd_occ <= i_job.in_range && r_occ[i_home];
        end else if ((r_state == B_PROBE) && !w_free && !w_last) begin
            r_idx <= n_idx;
            r_inc <= n_inc;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            key_mem[r_idx]  <= r_job.key;
            name_mem[r_idx] <= r_job.name;
        end
        if (w_rd) begin
            r_rd_key  <= key_mem[i_home];
            r_rd_name <= name_mem[i_home];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_done_probe || w_done_read) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_probe) begin
            r_status     <= w_free ? htpi_pkg::ST_INSERTED : htpi_pkg::ST_FULL;
            r_slot       <= w_free ? SW'(r_idx) : '0;
            r_slot_valid <= 1'b0;
            r_key        <= '0;
            r_name       <= '0;
        end else if (w_done_read) begin
            r_status     <= htpi_pkg::ST_READ;
            r_slot       <= r_job.read_slot;
            r_slot_valid <= r_rd_occ;
            r_key        <= r_rd_occ ? r_rd_key : '0;
            r_name       <= r_rd_occ ? r_rd_name : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_slot_valid = r_slot_valid;
    assign o_key_out    = r_key;
    assign o_name_out   = r_name;

endmodule

`default_nettype wire

>>> src/htpi_checker.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
`include "hash_table_probe_insert_assert.svh"

module htpi_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [htpi_pkg::STATUS_W-1:0]  o_status,
    input wire logic [htpi_pkg::SLOT_W-1:0]    o_slot,
    input wire logic                           o_slot_valid,
    input wire logic [htpi_pkg::KEY_W-1:0]     o_key_out,
    input wire logic [htpi_pkg::NAME_W-1:0]    o_name_out
);

    localparam int OW = 1 + htpi_pkg::STATUS_W + htpi_pkg::SLOT_W + 1
                      + htpi_pkg::KEY_W + htpi_pkg::NAME_W;

    logic [OW-1:0] w_out;
    logic          w_stall;
    logic          w_zero_data;
    logic          w_no_record;
    logic          w_not_read;
    logic          w_is_full;
    logic          w_empty_out;

    // Result channel as seen by the receiver
    assign w_out       = {o_valid, o_status, o_slot, o_slot_valid, o_key_out, o_name_out};
    assign w_stall     = o_valid && !i_ready;
    assign w_zero_data = (o_key_out == '0) && (o_name_out == '0);
    assign w_no_record = !o_slot_valid && w_zero_data;
    assign w_not_read  = o_valid && (o_status != htpi_pkg::ST_READ);
    assign w_is_full   = o_valid && (o_status == htpi_pkg::ST_FULL);
    assign w_empty_out = o_valid && !o_slot_valid;

    // No result shows right after reset
    `HTPI_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, !o_valid, "result valid after reset")

    // A stalled result keeps its transfer content
    `HTPI_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, w_stall, $stable(w_out), "result not held")

    // Insert and full results carry no record
    `HTPI_ASSERT_NOW(a_insert_clean, i_clk, i_rst_n, w_not_read, w_no_record, "insert with data")

    // A full table reports slot zero
    `HTPI_ASSERT_NOW(a_full_slot_zero, i_clk, i_rst_n, w_is_full, o_slot == '0, "slot set on full")

    // An empty slot reads back as zeros
    `HTPI_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, w_empty_out, w_zero_data, "empty read data")

endmodule

bind hash_table_probe_insert htpi_checker u_htpi_checker (.*);

`default_nettype wire

>>> bench/tb_hash_table_probe_insert.sv
// Self-checking bench for the open-addressing hash table with linear and quadratic probing.
`timescale 1ns / 100ps

module tb_hash_table_probe_insert;

    localparam int TABLE_SIZE    = 16;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam int REQ_W    = htpi_pkg::REQ_W;
    localparam int KEY_W    = htpi_pkg::KEY_W;
    localparam int NAME_W   = htpi_pkg::NAME_W;
    localparam int SLOT_W   = htpi_pkg::SLOT_W;
    localparam int STATUS_W = htpi_pkg::STATUS_W;

    // Undefined request code, decoded by the block as a read
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // One expected reply of the table
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                slot_valid;
        logic [KEY_W-1:0]    key_out;
        logic [NAME_W-1:0]   name_out;
    } t_probe_reply;

    // Mirror of the slot array; predicts each reply and checks it on arrival
    class t_hash_slot_scoreboard;
        bit               occupied [TABLE_SIZE];
        logic [KEY_W-1:0] keys     [TABLE_SIZE];
        logic [NAME_W-1:0] names   [TABLE_SIZE];
        t_probe_reply     replies_due[$];
        int               fail_count;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            fail_count = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // Accepted request: probe the mirror and queue the reply it causes
        function void note_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                   logic [NAME_W-1:0] name, logic [SLOT_W-1:0] rs);
            t_probe_reply r;
            int home;
            int idx;
            int found;
            r = '0;
            if (req == htpi_pkg::REQ_LINEAR || req == htpi_pkg::REQ_QUAD) begin
                home  = int'(key % TABLE_SIZE);
                found = -1;
                for (int i = 0; i < TABLE_SIZE && found < 0; i++) begin
                    idx = (home + ((req == htpi_pkg::REQ_QUAD) ? i * i : i)) % TABLE_SIZE;
                    if (!occupied[idx]) found = idx;
                end
                if (found < 0) begin
                    r.status = htpi_pkg::ST_FULL;
                end else begin
                    occupied[found] = 1'b1;
                    keys[found]     = key;
                    names[found]    = name;
                    r.status        = htpi_pkg::ST_INSERTED;
                    r.slot          = SLOT_W'(found);
                end
            end else begin
                // read; anything out of range looks empty
                r.status = htpi_pkg::ST_READ;
                r.slot   = rs;
                if (int'(rs) < TABLE_SIZE && occupied[rs]) begin
                    r.slot_valid = 1'b1;
                    r.key_out    = keys[rs];
                    r.name_out   = names[rs];
                end
            end
            replies_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [63:0] exp, logic [63:0] act);
            if (act !== exp) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, exp, act);
                fail_count++;
            end
        endfunction

        // Result transfer: compare against the oldest queued reply
        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                   logic slot_valid, logic [KEY_W-1:0] key_out,
                                   logic [NAME_W-1:0] name_out);
            t_probe_reply r;
            if (replies_due.size() == 0) begin
                $error("result transfer with no reply pending: status %0d slot %0d",
                       status, slot);
                fail_count++;
                return;
            end
            r = replies_due.pop_front();
            compare_field("status", 64'(r.status), 64'(status));
            compare_field("slot", 64'(r.slot), 64'(slot));
            compare_field("slot_valid", 64'(r.slot_valid), 64'(slot_valid));
            compare_field("key_out", 64'(r.key_out), 64'(key_out));
            compare_field("name_out", r.name_out, name_out);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [REQ_W-1:0]    i_req_type;
    logic [KEY_W-1:0]    i_record_key;
    logic [NAME_W-1:0]   i_record_name;
    logic [SLOT_W-1:0]   i_read_slot;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_slot_valid;
    logic [KEY_W-1:0]    o_key_out;
    logic [NAME_W-1:0]   o_name_out;

    t_hash_slot_scoreboard sb = new();

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  sink_hold_req = 1'b0;
    int  cycle_count   = 0;

    hash_table_probe_insert #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_record_key (i_record_key),
        .i_record_name(i_record_name),
        .i_read_slot  (i_read_slot),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_slot_valid (o_slot_valid),
        .o_key_out    (o_key_out),
        .o_name_out   (o_name_out)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sample both channels at the rising edge; requests first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(i_req_type, i_record_key, i_record_name, i_read_slot);
            if (o_valid && i_ready)
                sb.check_result(o_status, o_slot, o_slot_valid, o_key_out, o_name_out);
        end
    end

    // Result-side ready: random stalls, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                hold_left     = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one request and return once it has transferred
    task automatic send_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                logic [NAME_W-1:0] name, logic [SLOT_W-1:0] rs);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_record_key  <= key;
        i_record_name <= name;
        i_read_slot   <= rs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Mix of inserts of both kinds and reads, with the spare code now and then
    task automatic send_random_request();
        logic [REQ_W-1:0]  req;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 35)      req = htpi_pkg::REQ_LINEAR;
        else if (pick < 60) req = htpi_pkg::REQ_QUAD;
        else if (pick < 90) req = htpi_pkg::REQ_READ;
        else                req = REQ_SPARE;
        key  = KEY_W'({$urandom, $urandom});
        name = {$urandom, $urandom};
        send_request(req, key, name, SLOT_W'($urandom_range(TABLE_SIZE - 1)));
    endtask

    // Drop valid and hold off until every reply is back
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = htpi_pkg::REQ_LINEAR;
        i_record_key  = '0;
        i_record_name = '0;
        i_read_slot   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 15;
        sink_idle_pct = 47;

        // Directed: empty reads, quadratic chain off home 0 until it reports
        // full with slots free, wrap-around and duplicate linear inserts, reads back
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd0);
        send_request(REQ_SPARE, '0, '0, 4'd15);
        send_request(htpi_pkg::REQ_QUAD, 34'd0, '0, '0);
        send_request(htpi_pkg::REQ_QUAD, 34'd16, 64'h0123_4567_89ab_cdef, '0);
        send_request(htpi_pkg::REQ_QUAD, 34'd32, 64'h4d41_5249_4e45_5200, '0);
        send_request(htpi_pkg::REQ_QUAD, 34'd48, 64'h5a45_4252_4120_2020, '0);
        send_request(htpi_pkg::REQ_QUAD, 34'd64, 64'hdead_beef_cafe_f00d, '0);
        send_request(htpi_pkg::REQ_LINEAR, {KEY_W{1'b1}}, {NAME_W{1'b1}}, '0);
        send_request(htpi_pkg::REQ_LINEAR, 34'd15, 64'h1111_2222_3333_4444, '0);
        send_request(htpi_pkg::REQ_LINEAR, 34'd15, 64'h5555_6666_7777_8888, '0);
        send_request(htpi_pkg::REQ_LINEAR, 34'd9999999999, 64'h3939_3939_3939_3939, '0);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd0);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd15);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd2);
        send_request(REQ_SPARE, '0, '0, 4'd3);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd4);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd5);
        send_request(htpi_pkg::REQ_READ, '0, '0, 4'd7);
        send_request(REQ_SPARE, '0, '0, 4'd9);
        pause_until_drained();

        // Random, sender lightly idle and receiver heavily stalled
        repeat (430) send_random_request();
        pause_until_drained();

        // Random, roles swapped
        src_idle_pct  = 47;
        sink_idle_pct = 15;
        repeat (430) send_random_request();
        pause_until_drained();

        // No idling; a long receiver hold-off lets the block back up first
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold_req = 1'b1;
        repeat (440) send_random_request();
        pause_until_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
